/* hdl/wtrt_pkg.sv */
`timescale 1ns / 1ps
package wtrt_pkg;
    localparam int Capacity    = 256;
    localparam int WindowTicks = 256;
    localparam int IdxW        = $clog2(Capacity);
    localparam int CntW        = $clog2(Capacity + 1);
    localparam int RecW        = 32 + 8 + 16 + 3 + 16 + 8 + 16 + 4 + 16;

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_REPL   = 2'd1,
        REQ_ATTR   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_EV_RD,
        S_EV_WAIT,
        S_EV_TEST,
        S_EV_MOVE_RD,
        S_EV_MOVE_WAIT,
        S_EV_MOVE_WR,
        S_Q_RD,
        S_Q_WAIT,
        S_Q_ACC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] tick;
        logic [7:0]  peer;
        logic [15:0] entity;
        logic [2:0]  category;
        logic [15:0] bytes;
        logic [7:0]  rule;
        logic [15:0] score;
        logic [3:0]  band;
        logic [15:0] schema;
    } rec_t;
endpackage

/* hdl/windowed_traffic_record_table.sv */
`timescale 1ns / 1ps
// windowed traffic record table
// input channel s_axis_*: one request per transfer; tdata holds, from bit 0 up:
//   req_type(2) tick(32) peer(8) entity(16) category(3) byte_count(16) rule_id(8)
//   priority_score(16) band_id(4) schema_id(16), zero padded to 128 bits
// output channel m_axis_*: result fields in tdata, last result of a request on tlast
// record: if not full, the append state writes the entry; an eviction sweep
//   reads every live entry through the one read port (read, wait, test states;
//   move read, wait, write per moved entry); replication and attribution
//   queries sweep the live entries once (read, wait, accumulate states)
// attribution gives six transfers, categories 0 to 5; others give one
// clear empties the table and zeroes the newest tick
// s_axis_tready is high only while the sequencer is idle; a stalled receiver holds
//   the result register and the sequencer waits on it
// reset empties the table and zeroes the newest tick; no clearing pass is needed
//   because only entries below the fill count are ever read
module windowed_traffic_record_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // req_type tick peer entity category byte_count
                                        // rule_id priority_score band_id schema_id
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata,  // status found_tick found_entity found_rule
                                        // found_score found_band found_schema found_bytes
                                        // peer_bytes entity_count category_bytes
    output logic         m_axis_tlast
);
    import wtrt_pkg::*;

    rec_t mem [Capacity];
    rec_t rd_data_reg;
    logic [IdxW-1:0] rd_addr, wr_addr;
    logic wr_en;
    rec_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next, idx_reg, idx_next;
    logic [31:0] newest_reg, newest_next;
    req_t req_reg, req_next;
    rec_t in_reg, in_next;
    logic [32:0] oldest_reg, oldest_next;
    logic found_reg, found_next;
    rec_t best_reg, best_next;
    logic [23:0] total_reg, total_next;
    logic [8:0] cnt_reg, cnt_next;
    logic [23:0] cat_reg [6];
    logic [23:0] cat_next [6];
    logic [2:0] k_reg, k_next;
    logic [1:0] status_reg, status_next;
    logic ovalid_reg, ovalid_next;

    rec_t in_rec;
    assign in_rec = '{tick: s_axis_tdata[33:2], peer: s_axis_tdata[41:34],
                      entity: s_axis_tdata[57:42], category: s_axis_tdata[60:58],
                      bytes: s_axis_tdata[76:61], rule: s_axis_tdata[84:77],
                      score: s_axis_tdata[100:85], band: s_axis_tdata[104:101],
                      schema: s_axis_tdata[120:105]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            newest_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            newest_reg <= newest_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        req_reg    <= req_next;
        in_reg     <= in_next;
        oldest_reg <= oldest_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        total_reg  <= total_next;
        cnt_reg    <= cnt_next;
        cat_reg    <= cat_next;
        k_reg      <= k_next;
        status_reg <= status_next;
    end

    function automatic logic [23:0] sat24(input logic [23:0] a, input logic [15:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[24] ? 24'hFFFFFF : s[23:0];
    endfunction

    // newest tick is already raised when the append state runs
    logic [32:0] oldest_calc;
    assign oldest_calc = (newest_reg > 32'(WindowTicks))
                       ? {1'b0, newest_reg} - 33'(WindowTicks) : '0;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        newest_next = newest_reg;
        req_next    = req_reg;
        in_next     = in_reg;
        oldest_next = oldest_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        cat_next    = cat_reg;
        k_next      = k_reg;
        status_next = status_reg;
        ovalid_next = ovalid_reg;
        rd_addr     = idx_reg[IdxW-1:0];
        wr_addr     = idx_reg[IdxW-1:0];
        wr_en       = 1'b0;
        wr_data     = in_reg;
        s_axis_tready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next    = req_t'(s_axis_tdata[1:0]);
                    in_next     = in_rec;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    best_next   = '0;
                    total_next  = '0;
                    cnt_next    = '0;
                    for (int c = 0; c < 6; c++) cat_next[c] = '0;
                    k_next      = '0;
                    status_next = ST_OK;
                    unique case (req_t'(s_axis_tdata[1:0]))
                        REQ_RECORD:
                        begin
                            if (in_rec.tick > newest_reg) newest_next = in_rec.tick;
                            if (count_reg >= CntW'(Capacity))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                state_next = S_APPEND;
                            end
                        end
                        REQ_REPL, REQ_ATTR: state_next = S_Q_RD;
                        default:
                        begin
                            count_next  = '0;
                            newest_next = '0;
                            state_next  = S_OUT;
                        end
                    endcase
                end
            end
            S_APPEND:
            begin
                wr_en       = 1'b1;
                wr_addr     = count_reg[IdxW-1:0];
                count_next  = count_reg + 1'b1;
                oldest_next = oldest_calc;
                state_next  = S_EV_RD;
            end
            S_EV_RD:
            begin
                if (idx_reg >= count_reg) state_next = S_OUT;
                else state_next = S_EV_WAIT;
            end
            S_EV_WAIT: state_next = S_EV_TEST;
            S_EV_TEST:
            begin
                if ({1'b0, rd_data_reg.tick} < oldest_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_EV_MOVE_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_EV_RD;
                end
            end
            S_EV_MOVE_RD:
            begin
                rd_addr    = count_reg[IdxW-1:0];
                state_next = S_EV_MOVE_WAIT;
            end
            S_EV_MOVE_WAIT:
            begin
                rd_addr    = count_reg[IdxW-1:0];
                state_next = S_EV_MOVE_WR;
            end
            S_EV_MOVE_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data_reg;
                state_next = S_EV_RD;
            end
            S_Q_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    if (req_reg == REQ_REPL && !found_reg) status_next = ST_NOTFOUND;
                    state_next = S_OUT;
                end
                else state_next = S_Q_WAIT;
            end
            S_Q_WAIT: state_next = S_Q_ACC;
            S_Q_ACC:
            begin
                if (req_reg == REQ_REPL)
                begin
                    if (rd_data_reg.peer == in_reg.peer && rd_data_reg.entity == in_reg.entity
                        && (!found_reg || rd_data_reg.tick >= best_reg.tick))
                    begin
                        found_next = 1'b1;
                        best_next  = rd_data_reg;
                    end
                end
                else if (rd_data_reg.peer == in_reg.peer && rd_data_reg.tick == in_reg.tick)
                begin
                    total_next = sat24(total_reg, rd_data_reg.bytes);
                    if (rd_data_reg.category < 3'd6)
                        cat_next[rd_data_reg.category] =
                            sat24(cat_reg[rd_data_reg.category], rd_data_reg.bytes);
                    if (cnt_reg != 9'h1FF) cnt_next = cnt_reg + 1'b1;
                    if (rd_data_reg.bytes > best_reg.bytes) best_next = rd_data_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_Q_RD;
            end
            S_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                end
                else if (m_axis_tready)
                begin
                    if (req_reg == REQ_ATTR && k_reg != 3'd5)
                    begin
                        k_next = k_reg + 1'b1;
                    end
                    else
                    begin
                        ovalid_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic [31:0] o_tick;
    logic [15:0] o_ent, o_schema, o_bytes;
    logic [7:0]  o_rule;
    logic [15:0] o_score;
    logic [3:0]  o_band;
    logic [23:0] o_total, o_cat;
    logic [8:0]  o_cnt;

    always_comb
    begin
        o_tick = '0; o_ent = '0; o_schema = '0; o_bytes = '0; o_rule = '0;
        o_score = '0; o_band = '0; o_total = '0; o_cat = '0; o_cnt = '0;
        if (req_reg == REQ_REPL && found_reg)
        begin
            o_tick  = best_reg.tick;
            o_rule  = best_reg.rule;
            o_score = best_reg.score;
            o_band  = best_reg.band;
            o_bytes = best_reg.bytes;
        end
        else if (req_reg == REQ_ATTR)
        begin
            o_tick   = in_reg.tick;
            o_ent    = best_reg.entity;
            o_schema = best_reg.schema;
            o_bytes  = best_reg.bytes;
            o_total  = total_reg;
            o_cnt    = cnt_reg;
            o_cat    = cat_reg[k_reg];
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast  = (req_reg != REQ_ATTR) || (k_reg == 3'd5);
    assign m_axis_tdata  = {1'b0, o_cat, o_cnt, o_total, o_bytes, o_schema, o_band,
                            o_score, o_rule, o_ent, o_tick, status_reg};
endmodule

/* hdl/wtrt_checker.sv */
`timescale 1ns / 1ps
module wtrt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [167:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    import wtrt_pkg::*;

    // no new request while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while output pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status code");

    // a full or not found result stands alone
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tlast)
        else $error("error status without tlast");
endmodule

bind windowed_traffic_record_table wtrt_checker u_wtrt_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast));
